@@ sv/fps_pkg.sv @@
// shared types, constants and pattern byte mapping for the pattern substitute block
`default_nettype none
package fps_pkg;

    localparam int PAT_BYTES = 16;
    localparam int CELLS     = PAT_BYTES - 1;
    localparam int CFG_IDX_W = 3;
    localparam int CFG_W     = 64;

    localparam logic [CFG_IDX_W-1:0] CFG_FIND_LO  = 3'd0;
    localparam logic [CFG_IDX_W-1:0] CFG_FIND_HI  = 3'd1;
    localparam logic [CFG_IDX_W-1:0] CFG_REPL_LO  = 3'd2;
    localparam logic [CFG_IDX_W-1:0] CFG_REPL_HI  = 3'd3;
    localparam logic [CFG_IDX_W-1:0] CFG_GUID_SWP = 3'd4;

    typedef logic [PAT_BYTES-1:0][7:0] t_pat;

    typedef struct packed {
        logic       valid;
        logic       last;
        logic [7:0] data;
    } t_slot;

    // byte idx of a 16-byte pattern, optionally through the guid mixed-endian swap
    function automatic logic [7:0] pat_byte(input logic [63:0] lo, input logic [63:0] hi,
                                            input logic swap, input logic [3:0] idx);
        logic [3:0] src;
        src = idx;
        if (swap) begin
            if (src < 4'd4) begin
                src = 4'd3 - src;
            end else if (src < 4'd8) begin
                src = src ^ 4'd1;
            end
        end
        if (src[3]) begin
            pat_byte = hi[{src[2:0], 3'b000} +: 8];
        end else begin
            pat_byte = lo[{src[2:0], 3'b000} +: 8];
        end
    endfunction

endpackage
`default_nettype wire

@@ sv/fixed_pattern_substitute_top.sv @@
// top level of the fixed byte pattern find and replace block
//
// input channel: one byte per transaction (i_data_byte, i_is_last), valid/ready.
// output channel: one byte per transaction (o_out_byte, o_out_last, o_found_any).
// config: write i_cfg_data to register i_cfg_idx when i_cfg_we is high
// (find low/high, replace low/high, guid swap mode); write only while idle.
// a row of PAT_BYTES-1 cells holds the most recent bytes; together with the
// arriving byte they form the window, compared combinationally with the pattern.
// once the window is full each input byte but the last loads one output byte
// into the output register, at one byte per clock while the receiver keeps up.
// the first PAT_BYTES-1 bytes of a stream produce no output on arrival.
// after the last byte the row drains through the output register, one cell per
// cycle unless stalled; no input is taken until the final byte is loaded.
// o_found_any is set only on the final byte of a stream.
// a stalled receiver holds the output register; input is then held off too.
// reset empties the row, clears the found flag and loads default patterns
// (all zero, guid swap on).
`default_nettype none
module fixed_pattern_substitute_top (
    input  wire logic                           i_clk,
    input  wire logic                           i_rst_n,
    input  wire logic                           i_cfg_we,
    input  wire logic [fps_pkg::CFG_IDX_W-1:0]  i_cfg_idx,
    input  wire logic [fps_pkg::CFG_W-1:0]      i_cfg_data,
    input  wire logic                           i_in_valid,
    output logic                                o_in_ready,
    input  wire logic [7:0]                     i_data_byte,
    input  wire logic                           i_is_last,
    output logic                                o_out_valid,
    input  wire logic                           i_out_ready,
    output logic [7:0]                          o_out_byte,
    output logic                                o_out_last,
    output logic                                o_found_any
);
    import fps_pkg::*;

    t_pat              w_find;
    t_pat              w_repl;
    t_slot             w_fwd   [CELLS];
    logic [CELLS-1:0]  w_match;
    t_slot             w_head;

    logic       r_flushing;
    logic       r_found;
    logic       r_tail_valid;
    logic [7:0] r_tail_data;
    logic       r_out_valid;
    logic [7:0] r_out_byte;
    logic       r_out_last;
    logic       r_out_found;

    logic w_out_free;
    logic w_accept;
    logic w_full;
    logic w_hit;
    logic w_sub;
    logic w_shift;
    logic w_emit_run;
    logic w_emit_flush;
    logic [7:0] w_new_byte;

    fps_cfg u_cfg (
        .i_clk      (i_clk),
        .i_rst_n    (i_rst_n),
        .i_cfg_we   (i_cfg_we),
        .i_cfg_idx  (i_cfg_idx),
        .i_cfg_data (i_cfg_data),
        .o_find     (w_find),
        .o_repl     (w_repl)
    );

    assign w_out_free = !r_out_valid || i_out_ready;
    assign o_in_ready = !r_flushing && w_out_free;
    assign w_accept   = i_in_valid && o_in_ready;

    // cells fill from the top, so cell 0 valid means the window is full
    assign w_full = w_fwd[0].valid;
    assign w_hit  = w_full && (&w_match) && (i_data_byte == w_find[PAT_BYTES-1]);
    assign w_sub  = w_accept && w_hit;
    assign w_new_byte = w_hit ? w_repl[PAT_BYTES-1] : i_data_byte;

    assign w_shift      = (w_accept && !i_is_last) || (r_flushing && w_out_free);
    assign w_emit_run   = w_accept && !i_is_last && w_full;
    assign w_emit_flush = r_flushing && w_out_free && w_fwd[0].valid;

    always_comb begin
        if (r_flushing) begin
            w_head.valid = r_tail_valid;
            w_head.last  = 1'b1;
            w_head.data  = r_tail_data;
        end else begin
            w_head.valid = 1'b1;
            w_head.last  = 1'b0;
            w_head.data  = w_new_byte;
        end
    end

    for (genvar g = 0; g < CELLS; g++) begin : g_cell
        t_slot w_next;
        if (g == CELLS - 1) begin : g_top
            assign w_next = w_head;
        end else begin : g_mid
            assign w_next = w_fwd[g+1];
        end
        fps_cell u_cell (
            .i_clk   (i_clk),
            .i_rst_n (i_rst_n),
            .i_shift (w_shift),
            .i_sub   (w_sub),
            .i_next  (w_next),
            .i_find  (w_find[g]),
            .i_repl  (w_repl[g]),
            .o_fwd   (w_fwd[g]),
            .o_match (w_match[g])
        );
    end

    // control: flush state, sticky found flag, tail slot valid
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_flushing   <= 1'b0;
            r_found      <= 1'b0;
            r_tail_valid <= 1'b0;
        end else begin
            if (w_accept) begin
                if (w_hit) begin
                    r_found <= 1'b1;
                end
                if (i_is_last) begin
                    r_flushing   <= 1'b1;
                    r_tail_valid <= 1'b1;
                end
            end else if (r_flushing && w_out_free) begin
                r_tail_valid <= 1'b0;
                if (w_fwd[0].valid && w_fwd[0].last) begin
                    r_flushing <= 1'b0;
                    r_found    <= 1'b0;
                end
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (w_accept && i_is_last) begin
            r_tail_data <= w_new_byte;
        end
    end

    // output register
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_out_valid <= 1'b0;
        end else if (w_emit_run || w_emit_flush) begin
            r_out_valid <= 1'b1;
        end else if (i_out_ready) begin
            r_out_valid <= 1'b0;
        end
    end

    always_ff @(posedge i_clk) begin
        if (w_emit_run || w_emit_flush) begin
            r_out_byte  <= w_fwd[0].data;
            r_out_last  <= w_emit_flush && w_fwd[0].last;
            r_out_found <= w_emit_flush && w_fwd[0].last && r_found;
        end
    end

    assign o_out_valid = r_out_valid;
    assign o_out_byte  = r_out_byte;
    assign o_out_last  = r_out_last;
    assign o_found_any = r_out_found;

    a_found_with_last: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (o_out_valid && o_found_any) |-> o_out_last)
        else $error("found flag shown on a byte that is not the last");

    a_last_starts_flush: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (i_in_valid && o_in_ready && i_is_last) |=> (r_flushing && r_tail_valid))
        else $error("last input transaction did not start the drain");

    a_row_fills_from_top: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (!r_flushing && w_fwd[0].valid) |-> w_fwd[CELLS-1].valid)
        else $error("window row has a gap");

endmodule
`default_nettype wire

@@ sv/fps_cfg.sv @@
// configuration registers and the mapped find and replace patterns
`default_nettype none
module fps_cfg (
    input  wire logic                           i_clk,
    input  wire logic                           i_rst_n,
    input  wire logic                           i_cfg_we,
    input  wire logic [fps_pkg::CFG_IDX_W-1:0]  i_cfg_idx,
    input  wire logic [fps_pkg::CFG_W-1:0]      i_cfg_data,
    output fps_pkg::t_pat                       o_find,
    output fps_pkg::t_pat                       o_repl
);
    import fps_pkg::*;

    logic [63:0] r_find_lo;
    logic [63:0] r_find_hi;
    logic [63:0] r_repl_lo;
    logic [63:0] r_repl_hi;
    logic        r_swap;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_find_lo <= '0;
            r_find_hi <= '0;
            r_repl_lo <= '0;
            r_repl_hi <= '0;
            r_swap    <= 1'b1;
        end else if (i_cfg_we) begin
            case (i_cfg_idx)
                CFG_FIND_LO:  r_find_lo <= i_cfg_data;
                CFG_FIND_HI:  r_find_hi <= i_cfg_data;
                CFG_REPL_LO:  r_repl_lo <= i_cfg_data;
                CFG_REPL_HI:  r_repl_hi <= i_cfg_data;
                CFG_GUID_SWP: r_swap    <= i_cfg_data[0];
                default: ;
            endcase
        end
    end

    always_comb begin
        for (int i = 0; i < PAT_BYTES; i++) begin
            o_find[i] = pat_byte(r_find_lo, r_find_hi, r_swap, 4'(i));
            o_repl[i] = pat_byte(r_repl_lo, r_repl_hi, r_swap, 4'(i));
        end
    end

endmodule
`default_nettype wire

@@ sv/fps_cell.sv @@
// one window cell: holds a byte, compares it and hands it to its neighbor
`default_nettype none
module fps_cell (
    input  wire logic           i_clk,
    input  wire logic           i_rst_n,
    input  wire logic           i_shift,
    input  wire logic           i_sub,
    input  wire fps_pkg::t_slot i_next,
    input  wire logic [7:0]     i_find,
    input  wire logic [7:0]     i_repl,
    output fps_pkg::t_slot      o_fwd,
    output logic                o_match
);
    import fps_pkg::*;

    logic       r_valid;
    logic       r_last;
    logic [7:0] r_data;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_valid <= 1'b0;
            r_last  <= 1'b0;
        end else if (i_shift) begin
            r_valid <= i_next.valid;
            r_last  <= i_next.last;
        end
    end

    // a substitution without a shift rewrites the byte in place
    always_ff @(posedge i_clk) begin
        if (i_shift) begin
            r_data <= i_next.data;
        end else if (i_sub) begin
            r_data <= i_repl;
        end
    end

    assign o_match     = (r_data == i_find);
    assign o_fwd.valid = r_valid;
    assign o_fwd.last  = r_last;
    assign o_fwd.data  = i_sub ? i_repl : r_data;

endmodule
`default_nettype wire

@@ tb/tb.sv @@
// self-checking testbench for the pattern substitute block
module tb;

    import fps_pkg::*;

    localparam logic [CFG_IDX_W-1:0] REG_SPARE_FIRST = CFG_GUID_SWP + 1'b1;
    localparam int LONG_HOLD = 80;

    typedef struct packed {
        logic [7:0] data;
        logic       last;
    } t_in_beat;

    typedef struct packed {
        logic [7:0] data;
        logic       last;
        logic       found;
    } t_out_beat;

    logic                 clk = 1'b0;
    logic                 rst_n = 1'b0;
    logic                 cfg_we = 1'b0;
    logic [CFG_IDX_W-1:0] cfg_idx = '0;
    logic [CFG_W-1:0]     cfg_data = '0;
    logic                 in_valid = 1'b0;
    logic                 in_ready;
    logic [7:0]           data_byte = '0;
    logic                 is_last = 1'b0;
    logic                 out_valid;
    logic                 out_ready = 1'b0;
    logic [7:0]           out_byte;
    logic                 out_last;
    logic                 found_any;

    fixed_pattern_substitute_top u_top (
        .i_clk       (clk),
        .i_rst_n     (rst_n),
        .i_cfg_we    (cfg_we),
        .i_cfg_idx   (cfg_idx),
        .i_cfg_data  (cfg_data),
        .i_in_valid  (in_valid),
        .o_in_ready  (in_ready),
        .i_data_byte (data_byte),
        .i_is_last   (is_last),
        .o_out_valid (out_valid),
        .i_out_ready (out_ready),
        .o_out_byte  (out_byte),
        .o_out_last  (out_last),
        .o_found_any (found_any)
    );

    // predictor copy of the registers and the window
    logic [63:0] find_lo_q = '0;
    logic [63:0] find_hi_q = '0;
    logic [63:0] repl_lo_q = '0;
    logic [63:0] repl_hi_q = '0;
    logic        swap_q = 1'b1;
    logic [7:0]  held [PAT_BYTES-1];
    int          held_cnt = 0;
    logic        sub_seen = 1'b0;

    t_in_beat  stim_q [$];
    t_out_beat byte_exp_q [$];

    int  fail_count = 0;
    int  items_sent = 0;
    int  bytes_out = 0;
    int  streams_done = 0;
    int  subs_total = 0;
    bit  idle_on = 1'b1;
    bit  calm = 1'b0;
    int  hold_req = 0;
    int  hold_seen = 0;
    int  hold_left = 0;
    int  tx_gap = 0;
    int  rx_gap = 0;
    logic in_fire = 1'b0;

    initial begin
        forever #4 clk = ~clk;
    end

    initial begin
        #2400000;
        $display("fixed_pattern_substitute_top regression: fail");
        $finish;
    end

    function automatic t_pat expand_pattern(input logic [63:0] lo, input logic [63:0] hi,
                                            input logic swap);
        logic [127:0] raw;
        t_pat         res;
        int           src;
        raw = {hi, lo};
        for (int k = 0; k < PAT_BYTES; k++) begin
            src = k;
            if (swap && k < 4) begin
                src = 3 - k;
            end else if (swap && k < 8) begin
                src = k ^ 1;
            end
            res[k] = raw[src*8 +: 8];
        end
        return res;
    endfunction

    task automatic predict_substitution(input logic [7:0] d, input logic last);
        t_pat win;
        int   n;
        win = '0;
        n = held_cnt;
        for (int k = 0; k < n; k++) begin
            win[k] = held[k];
        end
        win[n] = d;
        n++;
        if (n == PAT_BYTES && win == expand_pattern(find_lo_q, find_hi_q, swap_q)) begin
            win = expand_pattern(repl_lo_q, repl_hi_q, swap_q);
            sub_seen = 1'b1;
            subs_total++;
        end
        if (!last) begin
            if (n == PAT_BYTES) begin
                byte_exp_q.push_back('{data: win[0], last: 1'b0, found: 1'b0});
                for (int k = 0; k < PAT_BYTES - 1; k++) begin
                    held[k] = win[k+1];
                end
                held_cnt = PAT_BYTES - 1;
            end else begin
                held[n-1] = d;
                held_cnt = n;
            end
        end else begin
            for (int k = 0; k < n; k++) begin
                byte_exp_q.push_back('{data: win[k], last: k == n - 1,
                                       found: (k == n - 1) && sub_seen});
            end
            held_cnt = 0;
            sub_seen = 1'b0;
            streams_done++;
        end
    endtask

    // monitor: compare first so a result never meets a prediction made at the same edge
    always @(posedge clk) begin : mon
        t_out_beat want;
        in_fire <= in_valid && in_ready;
        if (rst_n && out_valid && out_ready) begin
            if (byte_exp_q.size() == 0) begin
                $error("unexpected output byte %0h (last %0b)", out_byte, out_last);
                fail_count++;
            end else begin
                want = byte_exp_q.pop_front();
                bytes_out++;
                if (out_byte !== want.data) begin
                    $error("out_byte mismatch: expected %0h, actual %0h", want.data, out_byte);
                    fail_count++;
                end
                if (out_last !== want.last) begin
                    $error("out_last mismatch: expected %0b, actual %0b", want.last, out_last);
                    fail_count++;
                end
                if (found_any !== want.found) begin
                    $error("found_any mismatch: expected %0b, actual %0b", want.found,
                           found_any);
                    fail_count++;
                end
            end
        end
        if (rst_n && in_valid && in_ready) begin
            predict_substitution(data_byte, is_last);
        end
    end

    // sender
    always @(negedge clk) begin : drv
        t_in_beat nxt;
        if (!rst_n) begin
            in_valid <= 1'b0;
        end else if (!in_valid || in_fire) begin
            if (tx_gap > 0) begin
                tx_gap <= tx_gap - 1;
                in_valid <= 1'b0;
            end else if (stim_q.size() == 0) begin
                in_valid <= 1'b0;
            end else if (idle_on && !calm && $urandom_range(0, 5) == 0) begin
                tx_gap <= $urandom_range(0, 4);
                in_valid <= 1'b0;
            end else begin
                nxt = stim_q.pop_front();
                data_byte <= nxt.data;
                is_last <= nxt.last;
                in_valid <= 1'b1;
            end
        end
    end

    // receiver, with an occasional long hold-off on request
    always @(negedge clk) begin
        if (hold_seen != hold_req) begin
            hold_seen <= hold_req;
            hold_left <= LONG_HOLD - 1;
            out_ready <= 1'b0;
        end else if (hold_left > 0) begin
            hold_left <= hold_left - 1;
            out_ready <= 1'b0;
        end else if (rx_gap > 0) begin
            rx_gap <= rx_gap - 1;
            out_ready <= 1'b0;
        end else if (idle_on && !calm && $urandom_range(0, 4) == 0) begin
            rx_gap <= $urandom_range(0, 4);
            out_ready <= 1'b0;
        end else begin
            out_ready <= 1'b1;
        end
    end

    task automatic write_reg(input logic [CFG_IDX_W-1:0] idx, input logic [CFG_W-1:0] d);
        @(negedge clk);
        cfg_we <= 1'b1;
        cfg_idx <= idx;
        cfg_data <= d;
        case (idx)
            CFG_FIND_LO:  find_lo_q = d;
            CFG_FIND_HI:  find_hi_q = d;
            CFG_REPL_LO:  repl_lo_q = d;
            CFG_REPL_HI:  repl_hi_q = d;
            CFG_GUID_SWP: swap_q = d[0];
            default: ;
        endcase
        @(negedge clk);
        cfg_we <= 1'b0;
    endtask

    task automatic load_setup(input logic [63:0] fl, input logic [63:0] fh,
                              input logic [63:0] rl, input logic [63:0] rh, input logic swap);
        logic [63:0] swap_word;
        // upper bits of the mode word are don't-care
        swap_word = {$urandom, $urandom};
        swap_word[0] = swap;
        write_reg(CFG_FIND_LO, fl);
        write_reg(CFG_FIND_HI, fh);
        write_reg(CFG_REPL_LO, rl);
        write_reg(CFG_REPL_HI, rh);
        write_reg(CFG_GUID_SWP, swap_word);
    endtask

    task automatic load_random_setup();
        load_setup({$urandom, $urandom}, {$urandom, $urandom}, {$urandom, $urandom},
                   {$urandom, $urandom}, 1'($urandom_range(0, 1)));
    endtask

    task automatic push_byte(input logic [7:0] d, input logic last);
        stim_q.push_back('{data: d, last: last});
        items_sent++;
    endtask

    // random stream seeded with copies of the current find pattern, optionally damaged
    task automatic send_stream(input int len, input int plants, input bit corrupt,
                               input bit closes);
        t_pat       fp;
        logic [7:0] s [$];
        int         pos;
        int         flip;
        fp = expand_pattern(find_lo_q, find_hi_q, swap_q);
        for (int k = 0; k < len; k++) begin
            case ($urandom_range(0, 3))
                0: s.push_back(fp[$urandom_range(0, PAT_BYTES - 1)]);
                1: s.push_back($urandom_range(0, 1) ? 8'hFF : 8'h00);
                default: s.push_back(8'($urandom_range(0, 255)));
            endcase
        end
        if (len >= PAT_BYTES) begin
            repeat (plants) begin
                pos = $urandom_range(0, len - PAT_BYTES);
                for (int k = 0; k < PAT_BYTES; k++) begin
                    s[pos+k] = fp[k];
                end
                if (corrupt) begin
                    flip = $urandom_range(0, PAT_BYTES - 1);
                    s[pos+flip] = s[pos+flip] ^ (8'h01 << $urandom_range(0, 7));
                end
            end
        end
        for (int k = 0; k < len; k++) begin
            push_byte(s[k], closes && k == len - 1);
        end
    endtask

    // all queued input taken and all results seen, then let the block settle
    task automatic wait_drained();
        while (stim_q.size() != 0 || in_valid || byte_exp_q.size() != 0) begin
            @(posedge clk);
        end
        repeat (PAT_BYTES + 4) @(posedge clk);
    endtask

    initial begin : stim
        logic [7:0] rep;
        int         pick;
        int         len;
        repeat (9) @(posedge clk);
        @(negedge clk);
        rst_n <= 1'b1;
        repeat (2) @(negedge clk);

        // default registers: an all-zero stream matches the zero pattern
        for (int k = 0; k < PAT_BYTES; k++) begin
            push_byte(8'h00, k == PAT_BYTES - 1);
        end
        // short stream and single-byte stream pass through untouched
        push_byte(8'hFF, 1'b0);
        push_byte(8'h01, 1'b0);
        push_byte(8'h80, 1'b1);
        push_byte(8'h7F, 1'b1);
        wait_drained();

        // extremes with swap off; spare register indexes must be ignored
        load_setup('1, '1, '0, '0, 1'b0);
        for (int r = REG_SPARE_FIRST; r < (1 << CFG_IDX_W); r++) begin
            write_reg(r[CFG_IDX_W-1:0], '1);
        end
        items_sent = 0;
        send_stream(17, 1, 1'b0, 1'b1);
        send_stream(18, 1, 1'b1, 1'b1);
        wait_drained();

        // find and replace the same repeated byte: every later window sees the rewrite
        rep = 8'($urandom_range(0, 255));
        load_setup({8{rep}}, {8{rep}}, {8{rep}}, {8{rep}}, 1'b1);
        repeat (30) push_byte(rep, 1'b0);
        for (int k = 0; k < 4; k++) begin
            push_byte(8'($urandom_range(0, 255)), k == 3);
        end
        hold_req++;
        wait_drained();

        load_setup('0, '0, '1, '1, 1'b1);
        send_stream(16, 1, 1'b0, 1'b1);
        wait_drained();

        // registers rewritten while a stream is half way in
        load_random_setup();
        send_stream(5, 0, 1'b0, 1'b0);
        wait_drained();
        load_random_setup();
        send_stream(20, 1, 1'b0, 1'b1);

        while (items_sent < 110) begin
            wait_drained();
            load_random_setup();
            idle_on = $urandom_range(0, 3) != 0;
            repeat ($urandom_range(1, 3)) begin
                pick = $urandom_range(0, 9);
                if (pick < 2) begin
                    len = $urandom_range(1, PAT_BYTES - 1);
                end else if (pick < 9) begin
                    len = $urandom_range(PAT_BYTES, 2 * PAT_BYTES);
                end else begin
                    len = $urandom_range(2 * PAT_BYTES + 1, 3 * PAT_BYTES);
                end
                send_stream(len, $urandom_range(0, 2), $urandom_range(0, 3) == 0, 1'b1);
                if ($urandom_range(0, 3) == 0) begin
                    wait_drained();
                end
            end
        end

        // closing stretch at full rate
        wait_drained();
        calm = 1'b1;
        idle_on = 1'b0;
        load_random_setup();
        send_stream(20, 1, 1'b0, 1'b1);
        wait_drained();

        $display("summary: %0d streams, %0d bytes checked, %0d window substitutions",
                 streams_done, bytes_out, subs_total);
        $display("covered swap on and off, all-zero/all-ones patterns, chained rewrites,"
                 , " mid-stream register change and a long output stall");
        if (fail_count == 0) begin
            $display("fixed_pattern_substitute_top regression: pass");
        end else begin
            $display("fixed_pattern_substitute_top regression: fail");
        end
        $finish;
    end

endmodule

@@ sim.f @@
sv/fps_pkg.sv
sv/fps_cfg.sv
sv/fps_cell.sv
sv/fixed_pattern_substitute_top.sv
tb/tb.sv
